### hdl/ffsa_pkg.sv
// Shared sizes, status codes and opcodes for the first-fit slot allocator.
// Used by first_fit_slot_allocator_top; depends on nothing else.
package ffsa_pkg;

   // Pool geometry.
   localparam int SLOTS      = 256;
   localparam int NUM_SPACES = 64;

   // Derived widths.
   localparam int SLOT_AW  = $clog2(SLOTS);
   localparam int SPACE_AW = $clog2(NUM_SPACES);
   localparam int OWN_W    = $clog2(NUM_SPACES + 1);
   localparam int CNT_W    = ($clog2(SLOTS + 1) > 9) ? $clog2(SLOTS + 1) : 9;
   localparam int LEN_W    = 9;
   localparam int SP_W     = SLOT_AW + LEN_W;

   // Fixed field widths.
   localparam int OPCODE_W = 2;
   localparam int ID_W     = 6;
   localparam int PLACE_W  = 8;
   localparam int STATUS_W = 3;
   localparam int START_W  = 8;
   localparam int OFFSET_W = 28;
   localparam int TIME_W   = 32;
   localparam int USE_W    = 9;
   localparam int SIZE_W   = 21;
   localparam int CSR_IDX_W = 1;

   // Register reset values.
   localparam logic [USE_W-1:0]  RESET_SLOTS_IN_USE = 9'd256;
   localparam logic [SIZE_W-1:0] RESET_SLOT_SIZE    = 21'd4096;

   // Register indexes.
   localparam logic [CSR_IDX_W-1:0] CSR_SLOTS_IN_USE = 1'b0;
   localparam logic [CSR_IDX_W-1:0] CSR_SLOT_SIZE    = 1'b1;

   // Opcodes.
   localparam logic [OPCODE_W-1:0] OP_ALLOC     = 2'd0;
   localparam logic [OPCODE_W-1:0] OP_RELEASE   = 2'd1;
   localparam logic [OPCODE_W-1:0] OP_RESET_ALL = 2'd2;
   localparam logic [OPCODE_W-1:0] OP_NONE      = 2'd3;

   // Result status codes.
   typedef enum logic [STATUS_W-1:0] {
      ST_OK          = 3'd0,
      ST_IN_USE      = 3'd1,
      ST_NO_RUN      = 3'd2,
      ST_RANGE       = 3'd3,
      ST_OVERLAP     = 3'd4,
      ST_OVERWRITTEN = 3'd5,
      ST_UNUSED      = 3'd6
   } status_type;

endpackage

### hdl/ffsa_ram.sv
// Generic single-clock RAM with one write port and one registered read port.
// Depends on nothing else.
module ffsa_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_array [DEPTH];

   // Write and registered read.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_array[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data <= mem_array[rd_addr];
      end
   end

endmodule

### hdl/first_fit_slot_allocator_top.sv
// Top level of the first-fit contiguous slot allocator.
// Depends on ffsa_pkg and ffsa_ram.
//
//   Port group  Direction  Flow control     Carries
//   req_*       in         valid / stall    opcode, space id, first_fit, place, run length
//   rsp_*       out        valid / stall    status, start slot, byte offset, event time
//   csr_*       in         valid / ready    register index and write data
//
// One transaction is worked at a time. A request refused at the check and reset-all go
// straight to the result, the unused opcode returns to idle with no result, release walks
// the run, allocate at a given place makes one owner read and one write per slot, and
// first-fit allocate scans the slots until a run fits and then writes that run, or scans the
// whole pool when no run fits. Reset frees all slots and spaces at once through per-entry
// valid flops. A finished result waits in the output register while the next request is
// taken; a stalled result holds the sequencer in its last state.
module first_fit_slot_allocator_top (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_stall,
   input  logic [ffsa_pkg::OPCODE_W-1:0]   req_opcode,
   input  logic [ffsa_pkg::ID_W-1:0]       req_space_id,
   input  logic                            req_first_fit,
   input  logic [ffsa_pkg::PLACE_W-1:0]    req_place,
   input  logic [ffsa_pkg::LEN_W-1:0]      req_run_length,
   input  logic                            req_reallocation,
   output logic                            rsp_valid,
   input  logic                            rsp_stall,
   output logic [ffsa_pkg::STATUS_W-1:0]   rsp_status,
   output logic [ffsa_pkg::START_W-1:0]    rsp_start_slot,
   output logic [ffsa_pkg::OFFSET_W-1:0]   rsp_byte_offset,
   output logic [ffsa_pkg::TIME_W-1:0]     rsp_event_time,
   input  logic                            csr_valid,
   output logic                            csr_ready,
   input  logic [ffsa_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [ffsa_pkg::SIZE_W-1:0]     csr_wdata
);

   localparam int CNT_W   = ffsa_pkg::CNT_W;
   localparam int SLOT_AW = ffsa_pkg::SLOT_AW;
   localparam int PROD_W  = CNT_W + ffsa_pkg::SIZE_W;

   typedef enum logic [2:0] {
      S_IDLE,
      S_CHECK,
      S_FF_SCAN,
      S_OV_SCAN,
      S_CLAIM,
      S_REL_WALK,
      S_DONE
   } state_type;

   // Control registers.
   state_type                        state_ff, state_in;
   logic [ffsa_pkg::USE_W-1:0]       slots_in_use_ff, slots_in_use_in;
   logic [ffsa_pkg::SIZE_W-1:0]      slot_size_ff, slot_size_in;
   logic [ffsa_pkg::TIME_W-1:0]      ctr_ff, ctr_in;
   logic [ffsa_pkg::SLOTS-1:0]       own_valid_ff, own_valid_in;
   logic [ffsa_pkg::NUM_SPACES-1:0]  sp_valid_ff, sp_valid_in;
   logic                             pend_ff, pend_in;
   logic                             rsp_valid_ff, rsp_valid_in;

   // Request and working registers.
   logic [ffsa_pkg::OPCODE_W-1:0]    op_ff, op_in;
   logic [ffsa_pkg::ID_W-1:0]        id_ff, id_in;
   logic [ffsa_pkg::SPACE_AW-1:0]    sp_idx_ff, sp_idx_in;
   logic                             id_oor_ff, id_oor_in;
   logic                             sp_used_ff, sp_used_in;
   logic                             ff_mode_ff, ff_mode_in;
   logic [ffsa_pkg::PLACE_W-1:0]     place_ff, place_in;
   logic [ffsa_pkg::LEN_W-1:0]       len_ff, len_in;
   logic                             realloc_ff, realloc_in;
   logic [CNT_W-1:0]                 rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]                 chk_ptr_ff, chk_ptr_in;
   logic [CNT_W-1:0]                 base_ff, base_in;
   logic [CNT_W-1:0]                 end_ff, end_in;
   logic [ffsa_pkg::LEN_W-1:0]       run_ff, run_in;
   logic                             own_vq_ff, own_vq_in;
   logic                             rel_bad_ff, rel_bad_in;
   ffsa_pkg::status_type             res_status_ff, res_status_in;
   logic [CNT_W-1:0]                 res_start_ff, res_start_in;

   // Output registers.
   logic [ffsa_pkg::STATUS_W-1:0]    out_status_ff, out_status_in;
   logic [ffsa_pkg::START_W-1:0]     out_start_ff, out_start_in;
   logic [ffsa_pkg::OFFSET_W-1:0]    out_offset_ff, out_offset_in;
   logic [ffsa_pkg::TIME_W-1:0]      out_time_ff, out_time_in;

   // RAM ports.
   logic                             own_wr_en;
   logic [SLOT_AW-1:0]               own_wr_addr;
   logic [ffsa_pkg::OWN_W-1:0]       own_wr_data;
   logic                             own_rd_en;
   logic [SLOT_AW-1:0]               own_rd_addr;
   logic [ffsa_pkg::OWN_W-1:0]       own_rd_data;
   logic                             sp_wr_en;
   logic [ffsa_pkg::SP_W-1:0]        sp_wr_data;
   logic                             sp_rd_en;
   logic [ffsa_pkg::SPACE_AW-1:0]    sp_rd_addr;
   logic [ffsa_pkg::SP_W-1:0]        sp_rd_data;

   // Derived values.
   logic [CNT_W-1:0]                 pool_cnt;
   logic [ffsa_pkg::OWN_W-1:0]       own_q;
   logic [ffsa_pkg::OWN_W-1:0]       own_tag;
   logic [CNT_W-1:0]                 sp_place;
   logic [CNT_W-1:0]                 sp_size;
   logic [CNT_W-1:0]                 len_c;
   logic [CNT_W-1:0]                 place_c;
   logic [PROD_W-1:0]                offset_prod;
   logic                             req_accept;

   ffsa_ram #(
      .WIDTH (ffsa_pkg::OWN_W),
      .DEPTH (ffsa_pkg::SLOTS)
   ) u_owner_ram (
      .clock   (clock),
      .wr_en   (own_wr_en),
      .wr_addr (own_wr_addr),
      .wr_data (own_wr_data),
      .rd_en   (own_rd_en),
      .rd_addr (own_rd_addr),
      .rd_data (own_rd_data)
   );

   ffsa_ram #(
      .WIDTH (ffsa_pkg::SP_W),
      .DEPTH (ffsa_pkg::NUM_SPACES)
   ) u_space_ram (
      .clock   (clock),
      .wr_en   (sp_wr_en),
      .wr_addr (sp_idx_ff),
      .wr_data (sp_wr_data),
      .rd_en   (sp_rd_en),
      .rd_addr (sp_rd_addr),
      .rd_data (sp_rd_data)
   );

   // Handshakes and port outputs.
   assign req_stall       = (state_ff != S_IDLE);
   assign req_accept      = req_valid && !req_stall;
   assign csr_ready       = 1'b1;
   assign rsp_valid       = rsp_valid_ff;
   assign rsp_status      = out_status_ff;
   assign rsp_start_slot  = out_start_ff;
   assign rsp_byte_offset = out_offset_ff;
   assign rsp_event_time  = out_time_ff;

   // Effective pool size is the smaller of the register and the table depth.
   assign pool_cnt = (CNT_W'(slots_in_use_ff) < CNT_W'(ffsa_pkg::SLOTS)) ?
                     CNT_W'(slots_in_use_ff) : CNT_W'(ffsa_pkg::SLOTS);

   // An owner entry that was never written since the last clear reads as free.
   assign own_q   = own_vq_ff ? own_rd_data : '0;
   assign own_tag = ffsa_pkg::OWN_W'(id_ff) + ffsa_pkg::OWN_W'(1);

   assign sp_place = CNT_W'(sp_rd_data[ffsa_pkg::SP_W-1:ffsa_pkg::LEN_W]);
   assign sp_size  = CNT_W'(sp_rd_data[ffsa_pkg::LEN_W-1:0]);
   assign len_c    = CNT_W'(len_ff);
   assign place_c  = CNT_W'(place_ff);

   assign sp_wr_data  = {SLOT_AW'(base_ff), len_ff};
   assign own_wr_data = own_tag;
   assign own_wr_addr = SLOT_AW'(rd_ptr_ff);
   assign own_rd_addr = SLOT_AW'(rd_ptr_ff);
   assign sp_rd_addr  = ffsa_pkg::SPACE_AW'(req_space_id);

   assign offset_prod = PROD_W'(res_start_ff) * PROD_W'(slot_size_ff);

   // Next-state logic for the sequencer, tables and result.
   always_comb begin
      state_in        = state_ff;
      slots_in_use_in = slots_in_use_ff;
      slot_size_in    = slot_size_ff;
      ctr_in          = ctr_ff;
      own_valid_in    = own_valid_ff;
      sp_valid_in     = sp_valid_ff;
      pend_in         = pend_ff;
      rsp_valid_in    = rsp_valid_ff;
      op_in           = op_ff;
      id_in           = id_ff;
      sp_idx_in       = sp_idx_ff;
      id_oor_in       = id_oor_ff;
      sp_used_in      = sp_used_ff;
      ff_mode_in      = ff_mode_ff;
      place_in        = place_ff;
      len_in          = len_ff;
      realloc_in      = realloc_ff;
      rd_ptr_in       = rd_ptr_ff;
      chk_ptr_in      = chk_ptr_ff;
      base_in         = base_ff;
      end_in          = end_ff;
      run_in          = run_ff;
      own_vq_in       = own_vq_ff;
      rel_bad_in      = rel_bad_ff;
      res_status_in   = res_status_ff;
      res_start_in    = res_start_ff;
      out_status_in   = out_status_ff;
      out_start_in    = out_start_ff;
      out_offset_in   = out_offset_ff;
      out_time_in     = out_time_ff;
      own_wr_en       = 1'b0;
      own_rd_en       = 1'b0;
      sp_wr_en        = 1'b0;
      sp_rd_en        = 1'b0;

      // Configuration writes.
      if (csr_valid) begin
         if (csr_index == ffsa_pkg::CSR_SLOTS_IN_USE) begin
            slots_in_use_in = csr_wdata[ffsa_pkg::USE_W-1:0];
         end else begin
            slot_size_in = csr_wdata;
         end
      end

      // Result register drains when the consumer takes it.
      if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end

      // Owner table walk: issue the next read while checking the last one.
      if ((state_ff == S_FF_SCAN || state_ff == S_OV_SCAN || state_ff == S_REL_WALK) &&
          (rd_ptr_ff < end_ff)) begin
         own_rd_en  = 1'b1;
         own_vq_in  = own_valid_ff[own_rd_addr];
         chk_ptr_in = rd_ptr_ff;
         rd_ptr_in  = rd_ptr_ff + CNT_W'(1);
         pend_in    = 1'b1;
      end else begin
         pend_in = 1'b0;
      end

      unique case (state_ff)
         S_IDLE: begin
            if (req_accept) begin
               op_in      = req_opcode;
               id_in      = req_space_id;
               sp_idx_in  = ffsa_pkg::SPACE_AW'(req_space_id);
               id_oor_in  = (int'(req_space_id) >= ffsa_pkg::NUM_SPACES);
               sp_used_in = sp_valid_ff[ffsa_pkg::SPACE_AW'(req_space_id)];
               ff_mode_in = req_first_fit;
               place_in   = req_place;
               len_in     = req_run_length;
               realloc_in = req_reallocation;
               sp_rd_en   = 1'b1;
               state_in   = S_CHECK;
            end
         end

         // Space entry is back from the RAM: run the request checks.
         S_CHECK: begin
            res_start_in = '0;
            rd_ptr_in    = '0;
            pend_in      = 1'b0;
            run_in       = '0;
            rel_bad_in   = 1'b0;
            unique case (op_ff)
               ffsa_pkg::OP_ALLOC: begin
                  if (id_oor_ff) begin
                     res_status_in = ffsa_pkg::ST_RANGE;
                     state_in      = S_DONE;
                  end else if (sp_used_ff) begin
                     res_status_in = ffsa_pkg::ST_IN_USE;
                     state_in      = S_DONE;
                  end else if (len_ff == '0) begin
                     res_status_in = ffsa_pkg::ST_RANGE;
                     state_in      = S_DONE;
                  end else if (ff_mode_ff) begin
                     end_in   = pool_cnt;
                     state_in = S_FF_SCAN;
                  end else if ((len_c > pool_cnt) || (place_c > pool_cnt - len_c)) begin
                     res_status_in = ffsa_pkg::ST_RANGE;
                     state_in      = S_DONE;
                  end else begin
                     rd_ptr_in = place_c;
                     base_in   = place_c;
                     end_in    = place_c + len_c;
                     state_in  = S_OV_SCAN;
                  end
               end
               ffsa_pkg::OP_RELEASE: begin
                  if (id_oor_ff || !sp_used_ff) begin
                     res_status_in = ffsa_pkg::ST_UNUSED;
                     state_in      = S_DONE;
                  end else begin
                     if (!realloc_ff) begin
                        ctr_in = ctr_ff + ffsa_pkg::TIME_W'(1);
                     end
                     rd_ptr_in    = sp_place;
                     end_in       = sp_place + sp_size;
                     res_start_in = sp_place;
                     state_in     = S_REL_WALK;
                  end
               end
               ffsa_pkg::OP_RESET_ALL: begin
                  own_valid_in  = '0;
                  sp_valid_in   = '0;
                  res_status_in = ffsa_pkg::ST_OK;
                  state_in      = S_DONE;
               end
               ffsa_pkg::OP_NONE: begin
                  state_in = S_IDLE;
               end
               default: begin
                  state_in = S_IDLE;
               end
            endcase
         end

         // First-fit search: track the length of the current free run.
         S_FF_SCAN: begin
            if (pend_ff) begin
               if (own_q != '0) begin
                  run_in = '0;
               end else if (run_ff + ffsa_pkg::LEN_W'(1) >= len_ff) begin
                  base_in   = chk_ptr_ff + CNT_W'(1) - len_c;
                  rd_ptr_in = chk_ptr_ff + CNT_W'(1) - len_c;
                  end_in    = chk_ptr_ff + CNT_W'(1);
                  ctr_in    = ctr_ff + ffsa_pkg::TIME_W'(1);
                  pend_in   = 1'b0;
                  state_in  = S_CLAIM;
               end else begin
                  run_in = run_ff + ffsa_pkg::LEN_W'(1);
               end
            end else if (rd_ptr_ff >= end_ff) begin
               res_status_in = ffsa_pkg::ST_NO_RUN;
               state_in      = S_DONE;
            end
         end

         // Given run: every slot must be free before anything is written.
         S_OV_SCAN: begin
            if (pend_ff) begin
               if (own_q != '0) begin
                  res_status_in = ffsa_pkg::ST_OVERLAP;
                  pend_in       = 1'b0;
                  state_in      = S_DONE;
               end
            end else if (rd_ptr_ff >= end_ff) begin
               rd_ptr_in = base_ff;
               ctr_in    = ctr_ff + ffsa_pkg::TIME_W'(1);
               state_in  = S_CLAIM;
            end
         end

         // Write the owner tag into each slot of the run, and the space entry with the last slot.
         S_CLAIM: begin
            own_wr_en                  = 1'b1;
            own_valid_in[own_wr_addr]  = 1'b1;
            rd_ptr_in                  = rd_ptr_ff + CNT_W'(1);
            if (rd_ptr_ff + CNT_W'(1) >= end_ff) begin
               sp_wr_en               = 1'b1;
               sp_valid_in[sp_idx_ff] = 1'b1;
               res_status_in          = ffsa_pkg::ST_OK;
               res_start_in           = base_ff;
               state_in               = S_DONE;
            end
         end

         // Release: free each slot and flag any not owned by this space.
         S_REL_WALK: begin
            if (pend_ff) begin
               own_valid_in[SLOT_AW'(chk_ptr_ff)] = 1'b0;
               if (own_q != own_tag) begin
                  rel_bad_in = 1'b1;
               end
            end else if (rd_ptr_ff >= end_ff) begin
               sp_valid_in[sp_idx_ff] = 1'b0;
               res_status_in = rel_bad_ff ? ffsa_pkg::ST_OVERWRITTEN : ffsa_pkg::ST_OK;
               state_in      = S_DONE;
            end
         end

         // Hand the result to the output register once it is free.
         S_DONE: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               out_status_in = res_status_ff;
               out_start_in  = res_start_ff[ffsa_pkg::START_W-1:0];
               out_offset_in = offset_prod[ffsa_pkg::OFFSET_W-1:0];
               out_time_in   = ctr_ff;
               rsp_valid_in  = 1'b1;
               state_in      = S_IDLE;
            end
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // State, tables' valid flops and registered outputs.
   always_ff @(posedge clock) begin
      op_ff         <= op_in;
      id_ff         <= id_in;
      sp_idx_ff     <= sp_idx_in;
      id_oor_ff     <= id_oor_in;
      sp_used_ff    <= sp_used_in;
      ff_mode_ff    <= ff_mode_in;
      place_ff      <= place_in;
      len_ff        <= len_in;
      realloc_ff    <= realloc_in;
      rd_ptr_ff     <= rd_ptr_in;
      chk_ptr_ff    <= chk_ptr_in;
      base_ff       <= base_in;
      end_ff        <= end_in;
      run_ff        <= run_in;
      own_vq_ff     <= own_vq_in;
      rel_bad_ff    <= rel_bad_in;
      res_status_ff <= res_status_in;
      res_start_ff  <= res_start_in;
      out_status_ff <= out_status_in;
      out_start_ff  <= out_start_in;
      out_offset_ff <= out_offset_in;
      out_time_ff   <= out_time_in;
      if (reset) begin
         state_ff        <= S_IDLE;
         slots_in_use_ff <= ffsa_pkg::RESET_SLOTS_IN_USE;
         slot_size_ff    <= ffsa_pkg::RESET_SLOT_SIZE;
         ctr_ff          <= '0;
         own_valid_ff    <= '0;
         sp_valid_ff     <= '0;
         pend_ff         <= 1'b0;
         rsp_valid_ff    <= 1'b0;
      end else begin
         state_ff        <= state_in;
         slots_in_use_ff <= slots_in_use_in;
         slot_size_ff    <= slot_size_in;
         ctr_ff          <= ctr_in;
         own_valid_ff    <= own_valid_in;
         sp_valid_ff     <= sp_valid_in;
         pend_ff         <= pend_in;
         rsp_valid_ff    <= rsp_valid_in;
      end
   end

endmodule

### tb/first_fit_slot_allocator_top_test.sv
`timescale 1ns / 100ps
// Self-checking testbench for the first-fit slot allocator (first_fit_slot_allocator_top).
// Depends on ffsa_pkg and the allocator RTL; a tracker class predicts and checks each result.
module first_fit_slot_allocator_top_test;

   localparam int DRAIN_CYCLES    = 600;
   localparam int NUM_PHASES      = 8;
   localparam int ITEMS_PER_PHASE = 235;
   localparam int HOLD_CYCLES     = 400;

   // One request transaction, in port order.
   typedef struct packed {
      logic [ffsa_pkg::OPCODE_W-1:0] opcode;
      logic [ffsa_pkg::ID_W-1:0]     space_id;
      logic                          first_fit;
      logic [ffsa_pkg::PLACE_W-1:0]  place;
      logic [ffsa_pkg::LEN_W-1:0]    run_length;
      logic                          reallocation;
   } request_type;

   // One expected result transaction.
   typedef struct {
      ffsa_pkg::status_type          status;
      logic [ffsa_pkg::START_W-1:0]  start_slot;
      logic [ffsa_pkg::OFFSET_W-1:0] byte_offset;
      logic [ffsa_pkg::TIME_W-1:0]   event_time;
   } outcome_type;

   // Tracks the slot pool, the space table and the event counter, and keeps the
   // outcomes of accepted requests until the block returns them.
   class slot_pool_tracker;
      logic [ffsa_pkg::OWN_W-1:0]  owner [ffsa_pkg::SLOTS];
      bit                          space_used [ffsa_pkg::NUM_SPACES];
      int                          space_place [ffsa_pkg::NUM_SPACES];
      int                          space_size [ffsa_pkg::NUM_SPACES];
      logic [ffsa_pkg::TIME_W-1:0] event_count;
      logic [ffsa_pkg::USE_W-1:0]  pool_slots;
      logic [ffsa_pkg::SIZE_W-1:0] bytes_per_slot;
      outcome_type                 pending_results [$];
      int                          mismatches;
      int                          checked;

      function new();
         pool_slots     = ffsa_pkg::RESET_SLOTS_IN_USE;
         bytes_per_slot = ffsa_pkg::RESET_SLOT_SIZE;
         event_count    = '0;
         mismatches     = 0;
         checked        = 0;
         free_all();
      endfunction

      function void free_all();
         foreach (owner[i]) owner[i] = '0;
         foreach (space_used[i]) begin
            space_used[i]  = 1'b0;
            space_place[i] = 0;
            space_size[i]  = 0;
         end
      endfunction

      function void set_register(logic [ffsa_pkg::CSR_IDX_W-1:0] idx,
                                 logic [ffsa_pkg::SIZE_W-1:0] value);
         if (idx == ffsa_pkg::CSR_SLOTS_IN_USE) pool_slots = value[ffsa_pkg::USE_W-1:0];
         else if (idx == ffsa_pkg::CSR_SLOT_SIZE) bytes_per_slot = value;
      endfunction

      // Effective slot count: the register clipped to the pool size.
      function int pool_count();
         return (int'(pool_slots) < ffsa_pkg::SLOTS) ? int'(pool_slots) : ffsa_pkg::SLOTS;
      endfunction

      // Allocation checks run in a fixed order; a rejection changes nothing.
      function ffsa_pkg::status_type allocate(request_type r, output int start);
         int count, where, run, len, id;
         bit found;
         count = pool_count();
         start = 0;
         id    = int'(r.space_id);
         where = int'(r.place);
         len   = int'(r.run_length);
         if (space_used[id]) return ffsa_pkg::ST_IN_USE;
         if (len == 0) return ffsa_pkg::ST_RANGE;
         if (r.first_fit) begin
            found = 1'b0;
            run   = 0;
            for (int i = 0; i < count && !found; i++) begin
               if (owner[i] != '0) begin
                  run = 0;
               end else begin
                  run++;
                  if (run >= len) begin
                     where = i + 1 - len;
                     found = 1'b1;
                  end
               end
            end
            if (!found) return ffsa_pkg::ST_NO_RUN;
         end
         if (len > count || where > count - len) return ffsa_pkg::ST_RANGE;
         for (int i = 0; i < len; i++)
            if (owner[where + i] != '0) return ffsa_pkg::ST_OVERLAP;
         event_count++;
         for (int i = 0; i < len; i++) owner[where + i] = ffsa_pkg::OWN_W'(id + 1);
         space_used[id]  = 1'b1;
         space_place[id] = where;
         space_size[id]  = len;
         start = where;
         return ffsa_pkg::ST_OK;
      endfunction

      // Release always completes for a used space; foreign slots flag an overwrite.
      function ffsa_pkg::status_type release_space(request_type r, output int start);
         int id, slot;
         ffsa_pkg::status_type st;
         id    = int'(r.space_id);
         start = 0;
         st    = ffsa_pkg::ST_OK;
         if (!space_used[id]) return ffsa_pkg::ST_UNUSED;
         if (!r.reallocation) event_count++;
         for (int i = 0; i < space_size[id]; i++) begin
            slot = space_place[id] + i;
            if (slot >= ffsa_pkg::SLOTS) begin
               st = ffsa_pkg::ST_OVERWRITTEN;
            end else begin
               if (owner[slot] != ffsa_pkg::OWN_W'(id + 1)) st = ffsa_pkg::ST_OVERWRITTEN;
               owner[slot] = '0;
            end
         end
         start = space_place[id];
         space_used[id]  = 1'b0;
         space_place[id] = 0;
         space_size[id]  = 0;
         return st;
      endfunction

      // Called for every accepted request; the unused opcode yields nothing.
      function void note_request(request_type r);
         outcome_type o;
         int          start;
         logic [63:0] product;
         start = 0;
         case (r.opcode)
            ffsa_pkg::OP_ALLOC:     o.status = allocate(r, start);
            ffsa_pkg::OP_RELEASE:   o.status = release_space(r, start);
            ffsa_pkg::OP_RESET_ALL: begin
               free_all();
               o.status = ffsa_pkg::ST_OK;
            end
            default:                return;
         endcase
         product       = 64'(start) * 64'(bytes_per_slot);
         o.start_slot  = ffsa_pkg::START_W'(start);
         o.byte_offset = product[ffsa_pkg::OFFSET_W-1:0];
         o.event_time  = event_count;
         pending_results = {pending_results, o};
      endfunction

      function void check_result(logic [ffsa_pkg::STATUS_W-1:0] status,
                                 logic [ffsa_pkg::START_W-1:0] start_slot,
                                 logic [ffsa_pkg::OFFSET_W-1:0] byte_offset,
                                 logic [ffsa_pkg::TIME_W-1:0] event_time);
         outcome_type e;
         checked++;
         if (pending_results.size() == 0) begin
            $error("result with no request waiting: status %0d", status);
            mismatches++;
            return;
         end
         e = pending_results.pop_front();
         if (status !== e.status) begin
            $error("status: expected %0d, actual %0d", e.status, status);
            mismatches++;
         end
         if (start_slot !== e.start_slot) begin
            $error("start_slot: expected %0d, actual %0d", e.start_slot, start_slot);
            mismatches++;
         end
         if (byte_offset !== e.byte_offset) begin
            $error("byte_offset: expected %0d, actual %0d", e.byte_offset, byte_offset);
            mismatches++;
         end
         if (event_time !== e.event_time) begin
            $error("event_time: expected %0d, actual %0d", e.event_time, event_time);
            mismatches++;
         end
      endfunction

      // A random space id that is free, or the fallback if none turns up quickly.
      function logic [ffsa_pkg::ID_W-1:0] unused_id(logic [ffsa_pkg::ID_W-1:0] fallback);
         logic [ffsa_pkg::ID_W-1:0] id;
         for (int i = 0; i < 16; i++) begin
            id = ffsa_pkg::ID_W'($urandom_range(0, ffsa_pkg::NUM_SPACES - 1));
            if (!space_used[id]) return id;
         end
         return fallback;
      endfunction

      function bit pick_used_id(output logic [ffsa_pkg::ID_W-1:0] id);
         int used_ids [$];
         id = '0;
         foreach (space_used[i]) if (space_used[i]) used_ids = {used_ids, i};
         if (used_ids.size() == 0) return 1'b0;
         id = ffsa_pkg::ID_W'(used_ids[$urandom_range(0, used_ids.size() - 1)]);
         return 1'b1;
      endfunction
   endclass

   logic                            clock = 1'b0;
   logic                            reset = 1'b1;
   logic                            req_valid = 1'b0;
   logic                            req_stall;
   logic [ffsa_pkg::OPCODE_W-1:0]   req_opcode = ffsa_pkg::OP_NONE;
   logic [ffsa_pkg::ID_W-1:0]       req_space_id = '0;
   logic                            req_first_fit = 1'b0;
   logic [ffsa_pkg::PLACE_W-1:0]    req_place = '0;
   logic [ffsa_pkg::LEN_W-1:0]      req_run_length = '0;
   logic                            req_reallocation = 1'b0;
   logic                            rsp_valid;
   logic                            rsp_stall = 1'b0;
   logic [ffsa_pkg::STATUS_W-1:0]   rsp_status;
   logic [ffsa_pkg::START_W-1:0]    rsp_start_slot;
   logic [ffsa_pkg::OFFSET_W-1:0]   rsp_byte_offset;
   logic [ffsa_pkg::TIME_W-1:0]     rsp_event_time;
   logic                            csr_valid = 1'b0;
   logic                            csr_ready;
   logic [ffsa_pkg::CSR_IDX_W-1:0]  csr_index = '0;
   logic [ffsa_pkg::SIZE_W-1:0]     csr_wdata = '0;

   slot_pool_tracker tracker = new();

   bit req_idle_on = 1'b1;
   bit rsp_idle_on = 1'b1;
   bit quiet_tail  = 1'b0;
   int hold_request = 0;
   int hold_left    = 0;
   int burst_left   = 0;
   int accepted     = 0;

   first_fit_slot_allocator_top dut (.*);

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // Global watchdog.
   initial begin
      #100_000_000;
      $display("*** FAILED ***");
      $finish;
   end

   // Result side: check each transaction and drive stall, with short random bursts
   // and one long hold-off that backs the block up.
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (rsp_valid && !rsp_stall)
            tracker.check_result(rsp_status, rsp_start_slot, rsp_byte_offset, rsp_event_time);
         if (hold_request > 0) begin
            hold_left    = hold_request;
            hold_request = 0;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_stall <= 1'b1;
         end else if (burst_left > 0) begin
            burst_left--;
            rsp_stall <= 1'b1;
         end else if (rsp_idle_on && !quiet_tail && $urandom_range(0, 4) == 0) begin
            burst_left = $urandom_range(0, 3);
            rsp_stall <= 1'b1;
         end else begin
            rsp_stall <= 1'b0;
         end
      end
   end

   // Offers one request and returns at the edge where it is taken.
   task automatic send_request(request_type r);
      if (req_idle_on && !quiet_tail && $urandom_range(0, 3) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 4)) @(posedge clock);
      end
      req_valid <= 1'b1;
      {req_opcode, req_space_id, req_first_fit, req_place, req_run_length,
       req_reallocation} <= r;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      tracker.note_request(r);
      accepted++;
   endtask

   // Leaves csr_valid high; the caller lowers it after the last write.
   task automatic csr_write(logic [ffsa_pkg::CSR_IDX_W-1:0] idx,
                            logic [ffsa_pkg::SIZE_W-1:0] value);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      tracker.set_register(idx, value);
   endtask

   task automatic program_pool(int slots, int size);
      csr_write(ffsa_pkg::CSR_SLOTS_IN_USE, ffsa_pkg::SIZE_W'(slots));
      csr_write(ffsa_pkg::CSR_SLOT_SIZE, ffsa_pkg::SIZE_W'(size));
      csr_valid <= 1'b0;
   endtask

   // Waits for every expected result, then lets a possible silent request finish.
   task automatic drain();
      while (tracker.pending_results.size() > 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   function automatic request_type make_request(logic [ffsa_pkg::OPCODE_W-1:0] op, int id,
                                                bit ff, int place, int len, bit realloc);
      request_type r;
      r.opcode       = op;
      r.space_id     = ffsa_pkg::ID_W'(id);
      r.first_fit    = ff;
      r.place        = ffsa_pkg::PLACE_W'(place);
      r.run_length   = ffsa_pkg::LEN_W'(len);
      r.reallocation = realloc;
      return r;
   endfunction

   // Mostly well-formed allocate and release traffic on the live pool, with some noise.
   function automatic request_type random_request();
      request_type               r;
      int                        count, sel, pick;
      logic [ffsa_pkg::ID_W-1:0] id;
      r     = request_type'($urandom);
      count = tracker.pool_count();
      sel   = $urandom_range(0, 99);
      if (sel < 52) begin
         r.opcode = ffsa_pkg::OP_ALLOC;
         if ($urandom_range(0, 4) != 0) r.space_id = tracker.unused_id(r.space_id);
         r.first_fit = ($urandom_range(0, 4) < 3);
         pick = $urandom_range(0, 99);
         if (pick < 70)
            r.run_length = ffsa_pkg::LEN_W'($urandom_range(1, (count < 8) ? count : 8));
         else if (pick < 85)
            r.run_length = ffsa_pkg::LEN_W'($urandom_range(1, count));
         else if (pick < 90)
            r.run_length = '0;
         if ($urandom_range(0, 4) != 0)
            r.place = ffsa_pkg::PLACE_W'($urandom_range(0, count - 1));
      end else if (sel < 90) begin
         r.opcode = ffsa_pkg::OP_RELEASE;
         if ($urandom_range(0, 4) != 0 && tracker.pick_used_id(id)) r.space_id = id;
      end else if (sel < 93) begin
         r.opcode = ffsa_pkg::OP_RESET_ALL;
      end else if (sel < 96) begin
         r.opcode = ffsa_pkg::OP_NONE;
      end
      return r;
   endfunction

   // Main sequence: reset, directed cases at the reset settings, then random phases.
   initial begin
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // Directed: every status but overwritten, field extremes, the ignored opcode and reset-all.
      send_request(make_request(ffsa_pkg::OP_RELEASE, 5, 0, 0, 0, 0));
      send_request(make_request(ffsa_pkg::OP_ALLOC, 0, 0, 0, 0, 0));
      send_request(make_request(ffsa_pkg::OP_ALLOC, 0, 0, 255, 2, 0));
      send_request(make_request(ffsa_pkg::OP_ALLOC, 63, 0, 255, 1, 1));
      send_request(make_request(ffsa_pkg::OP_ALLOC, 63, 1, 0, 1, 0));
      send_request(make_request(ffsa_pkg::OP_ALLOC, 1, 1, 0, 256, 0));
      send_request(make_request(ffsa_pkg::OP_ALLOC, 1, 0, 250, 10, 0));
      send_request(make_request(ffsa_pkg::OP_ALLOC, 2, 0, 0, 255, 0));
      send_request(make_request(ffsa_pkg::OP_ALLOC, 3, 0, 100, 1, 0));
      send_request(make_request(ffsa_pkg::OP_RELEASE, 2, 0, 0, 0, 1));
      send_request(make_request(ffsa_pkg::OP_ALLOC, 4, 1, 0, 511, 1));
      send_request(make_request(ffsa_pkg::OP_ALLOC, 4, 1, 200, 3, 0));
      send_request(make_request(ffsa_pkg::OP_NONE, 63, 1, 255, 511, 1));
      send_request(make_request(ffsa_pkg::OP_RELEASE, 63, 1, 255, 511, 0));
      send_request(make_request(ffsa_pkg::OP_RESET_ALL, 0, 0, 0, 0, 0));
      send_request(make_request(ffsa_pkg::OP_RELEASE, 4, 0, 0, 0, 0));
      send_request(make_request(ffsa_pkg::OP_ALLOC, 10, 0, 0, 256, 0));
      send_request(make_request(ffsa_pkg::OP_ALLOC, 11, 1, 0, 1, 0));
      send_request(make_request(ffsa_pkg::OP_RELEASE, 10, 0, 0, 0, 0));
      send_request(make_request(ffsa_pkg::OP_ALLOC, 0, 1, 255, 256, 0));
      send_request(make_request(ffsa_pkg::OP_RESET_ALL, 63, 1, 255, 511, 1));
      req_valid <= 1'b0;

      // Random phases, each under its own pool setting.
      for (int p = 0; p < NUM_PHASES; p++) begin
         drain();
         case (p)
            0: program_pool(256, 1048576);
            1: program_pool(1, 1);
            2: program_pool(16, 2097151);
            3: program_pool(256, 4096);
            4: program_pool(64, $urandom_range(1, 1048576));
            6: program_pool(200, 777);
            7: program_pool(256, 1);
            default: program_pool($urandom_range(1, 256), $urandom_range(1, 1048576));
         endcase
         req_idle_on = ($urandom_range(0, 3) != 0);
         rsp_idle_on = ($urandom_range(0, 3) != 0);
         quiet_tail  = (p == NUM_PHASES - 1);
         if (p == 3) hold_request = HOLD_CYCLES;
         for (int n = 0; n < ITEMS_PER_PHASE; n++) send_request(random_request());
         req_valid <= 1'b0;
      end
      drain();

      $display("Accepted %0d requests and checked %0d results over %0d pool settings.",
               accepted, tracker.checked, NUM_PHASES + 1);
      $display("Mismatches found: %0d.", tracker.mismatches);
      if (tracker.mismatches == 0 && tracker.pending_results.size() == 0)
         $display("*** PASSED ***");
      else
         $display("*** FAILED ***");
      $finish;
   end

endmodule
